// ===== rtl/itaf_pkg.sv =====
// Package for the integer-to-ASCII formatter: widths, format codes,
// character constants and the digit-to-character mapping.
// Depends on nothing; every other file of the block uses it.
package itaf_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_VALUE_W  = 32;

  // Digit counts: decimal uses log10(2) ~ 1233/4096.
  localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int NDIG       = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
  localparam int CNT_W      = $clog2(NDIG + 1);
  localparam int DCNT_W     = $clog2(VALUE_WIDTH + 1);

  typedef logic [1:0]             op_t;
  typedef logic [7:0]             char_t;
  typedef logic [3:0]             digit_t;
  typedef logic [VALUE_WIDTH-1:0] word_t;

  localparam op_t OP_UDEC = 2'd0;
  localparam op_t OP_SDEC = 2'd1;
  localparam op_t OP_OCT  = 2'd2;
  localparam op_t OP_HEX  = 2'd3;

  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_ALPHA = 8'h37;  // 'A' - 10
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_X     = 8'h78;

  function automatic char_t digit_char(input digit_t d);
    char_t c;
    if (d < 4'd10) begin
      c = CH_ZERO + char_t'(d);
    end else begin
      c = CH_ALPHA + char_t'(d);
    end
    return c;
  endfunction

endpackage

// ===== rtl/itaf_in_if.sv =====
// Request channel of the formatter: valid/ready handshake carrying the
// format code and the value. Depends on itaf_pkg.
interface itaf_in_if;
  logic                                  valid;
  logic                                  ready;
  itaf_pkg::op_t                         operation;
  logic [itaf_pkg::IN_VALUE_W-1:0]       value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== rtl/itaf_out_if.sv =====
// Character channel of the formatter: valid/ready handshake carrying one
// ASCII character and the end-of-text flag. Depends on itaf_pkg.
interface itaf_out_if;
  logic            valid;
  logic            ready;
  itaf_pkg::char_t ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter: unsigned/signed decimal, octal and hex text.
// Hex and octal values pass from acceptance through leading-zero trimming to the
// first character; decimal values first go through the BCD conversion.
// One character per cycle once emitting, while the output is not stalled; the
// decimal conversion runs on the one-bit-per-cycle BCD shifter.
// Reset (rst_n, synchronous, active low) empties the output register and idles.
module integer_to_ascii_formatter (
  input  logic       clk,
  input  logic       rst_n,
  itaf_in_if.sink    in_chan,
  itaf_out_if.source out_chan
);
  import itaf_pkg::*;

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_CONV = 2'd1;  // decimal: BCD shifter running
  localparam logic [1:0] S_TRIM = 2'd2;  // dropping leading zero digits
  localparam logic [1:0] S_EMIT = 2'd3;  // sending prefix, then digits

  logic [1:0] state_r, state_nxt;

  // Digit store, most significant digit at index NDIG-1 after trimming.
  digit_t [NDIG-1:0] dig_r, dig_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;     // significant digits still held
  logic [1:0]        pre_r, pre_nxt;     // prefix characters still to send
  op_t               mode_r, mode_nxt;

  logic  out_valid_r, out_valid_nxt;
  char_t out_ch_r, out_ch_nxt;
  logic  out_last_r, out_last_nxt;

  // Request decode.
  logic                        accept;
  word_t                       v_in, mag;
  logic                        neg, is_zero, is_dec;
  logic [3*NDIG-1:0]           oct_vec;
  logic [4*NDIG-1:0]           hex_vec, bcd_vec;
  logic [4*DEC_DIGITS-1:0]     bcd;
  logic                        conv_done;
  logic                        out_free;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // Only the low VALUE_WIDTH bits count; signed mode takes the magnitude,
  // which also covers the most negative value since the result is unsigned.
  assign v_in    = word_t'(in_chan.value);
  assign is_zero = (v_in == '0);
  assign neg     = (in_chan.operation == OP_SDEC) && v_in[VALUE_WIDTH-1];
  assign mag     = neg ? (~v_in + word_t'(1)) : v_in;
  assign is_dec  = (in_chan.operation == OP_UDEC) || (in_chan.operation == OP_SDEC);

  assign oct_vec = (3*NDIG)'(mag);
  assign hex_vec = (4*NDIG)'(mag);
  assign bcd_vec = (4*NDIG)'(bcd);

  itaf_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && is_dec),
    .bin   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // The output register may be loaded when empty or being taken this cycle,
  // so a new request can be accepted while the final character still waits.
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    pre_nxt       = pre_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt = in_chan.operation;
          cnt_nxt  = CNT_W'(NDIG);
          // Prefix: '-' for negative decimal, '0' for octal, "0x" for hex.
          // A zero value has no prefix in any format.
          if (is_zero) begin
            pre_nxt = 2'd0;
          end else if (in_chan.operation == OP_HEX) begin
            pre_nxt = 2'd2;
          end else if ((in_chan.operation == OP_OCT) || neg) begin
            pre_nxt = 2'd1;
          end else begin
            pre_nxt = 2'd0;
          end
          for (int i = 0; i < NDIG; i++) begin
            if (in_chan.operation == OP_OCT) begin
              dig_nxt[i] = {1'b0, oct_vec[3*i +: 3]};
            end else begin
              dig_nxt[i] = hex_vec[4*i +: 4];
            end
          end
          state_nxt = is_dec ? S_CONV : S_TRIM;
        end
      end

      S_CONV: begin
        if (conv_done) begin
          for (int i = 0; i < NDIG; i++) begin
            dig_nxt[i] = bcd_vec[4*i +: 4];
          end
          state_nxt = S_TRIM;
        end
      end

      S_TRIM: begin
        // Shift leading zeros out of the top, keeping at least one digit.
        if ((dig_r[NDIG-1] == 4'd0) && (cnt_r > CNT_W'(1))) begin
          for (int i = NDIG - 1; i > 0; i--) begin
            dig_nxt[i] = dig_r[i-1];
          end
          dig_nxt[0] = 4'd0;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pre_r != 2'd0) begin
            // Prefix characters are never last since digits follow.
            out_last_nxt = 1'b0;
            pre_nxt      = pre_r - 2'd1;
            if ((mode_r == OP_HEX) && (pre_r == 2'd1)) begin
              out_ch_nxt = CH_X;
            end else if (mode_r == OP_SDEC) begin
              out_ch_nxt = CH_MINUS;
            end else begin
              out_ch_nxt = CH_ZERO;
            end
          end else begin
            out_ch_nxt   = digit_char(dig_r[NDIG-1]);
            out_last_nxt = (cnt_r == CNT_W'(1));
            for (int i = NDIG - 1; i > 0; i--) begin
              dig_nxt[i] = dig_r[i-1];
            end
            dig_nxt[0] = 4'd0;
            cnt_nxt    = cnt_r - CNT_W'(1);
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pre_r       <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pre_r       <= pre_nxt;
    end
    dig_r      <= dig_nxt;
    mode_r     <= mode_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.ch    = out_ch_r;
  assign out_chan.last  = out_last_r;

endmodule

// ===== rtl/itaf_dabble.sv =====
// Bit-serial binary to BCD converter (shift-and-add-3), one bit per cycle.
// Depends on itaf_pkg.
module itaf_dabble (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  itaf_pkg::word_t                      bin,
  output logic                                 done,
  output logic [4*itaf_pkg::DEC_DIGITS-1:0]    bcd
);
  import itaf_pkg::*;

  localparam int BCD_W = 4 * DEC_DIGITS;

  word_t             sh_r, sh_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt, adj;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  // Each digit of 5 or more gets 3 added before the shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = bin;
      bcd_nxt  = '0;
      cnt_nxt  = DCNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], sh_r[VALUE_WIDTH-1]};
      sh_nxt  = {sh_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule
